// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the candidate filter merge stage.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define DFKCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, disabled during reset.
`define DFKCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dfkcf_pkg.sv =====
// ----------------------------------------------------------------------------
// DES fault key candidate filter package
// Field widths, the DES S-box table and the per-lane result type.
// ----------------------------------------------------------------------------
package dfkcf_pkg;

  localparam int unsigned LANES    = 8;
  localparam int unsigned GUESSES  = 64;
  localparam int unsigned EXP_W    = 48;
  localparam int unsigned DIFF_W   = 32;
  localparam int unsigned SIX_W    = 6;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned LANE_W   = 3;

  typedef struct packed {
    logic [GUESSES-1:0] cand;
    logic               tested;
  } lane_res_t;

  localparam logic [NIB_W-1:0] SBOX_ROM [0:LANES-1][0:GUESSES-1] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // Row from the outer two bits, column from the inner four.
  function automatic logic [NIB_W-1:0] sbox_lookup(input logic [LANE_W-1:0] lane,
                                                   input logic [SIX_W-1:0]  six);
    logic [SIX_W-1:0] addr;
    addr = {six[5], six[0], six[4:1]};
    return SBOX_ROM[lane][addr];
  endfunction

endpackage

// ===== rtl/core/dfkcf_ifs.sv =====
// ----------------------------------------------------------------------------
// DES fault key candidate filter channels
// Valid/ready channels for fault items and for candidate results.
// ----------------------------------------------------------------------------
interface dfkcf_in_if;
  logic                            valid;
  logic                            ready;
  logic [dfkcf_pkg::EXP_W-1:0]     r15_expanded;
  logic [dfkcf_pkg::EXP_W-1:0]     r15_faulty_expanded;
  logic [dfkcf_pkg::DIFF_W-1:0]    out_difference;
  logic [dfkcf_pkg::EXP_W-1:0]     fault_expanded;

  modport source(output valid, output r15_expanded, output r15_faulty_expanded,
                 output out_difference, output fault_expanded, input ready);
  modport sink(input valid, input r15_expanded, input r15_faulty_expanded,
               input out_difference, input fault_expanded, output ready);
endinterface

interface dfkcf_out_if;
  logic                              valid;
  logic                              ready;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox1_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox2_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox3_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox4_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox5_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox6_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox7_candidates;
  logic [dfkcf_pkg::GUESSES-1:0]     sbox8_candidates;
  logic [dfkcf_pkg::LANES-1:0]       lanes_tested;

  modport source(output valid, output sbox1_candidates, output sbox2_candidates,
                 output sbox3_candidates, output sbox4_candidates,
                 output sbox5_candidates, output sbox6_candidates,
                 output sbox7_candidates, output sbox8_candidates,
                 output lanes_tested, input ready);
  modport sink(input valid, input sbox1_candidates, input sbox2_candidates,
               input sbox3_candidates, input sbox4_candidates,
               input sbox5_candidates, input sbox6_candidates,
               input sbox7_candidates, input sbox8_candidates,
               input lanes_tested, output ready);
endinterface

// ===== rtl/core/dfkcf_lane.sv =====
// ----------------------------------------------------------------------------
// DES fault key candidate filter lane
// Tests all 64 subkey guesses for one S-box and registers the match mask.
// ----------------------------------------------------------------------------
module dfkcf_lane (
  input  logic                              clk,
  input  logic                              load,
  input  logic [dfkcf_pkg::LANE_W-1:0]      lane_idx,
  input  logic [dfkcf_pkg::SIX_W-1:0]       r_six,
  input  logic [dfkcf_pkg::SIX_W-1:0]       rf_six,
  input  logic [dfkcf_pkg::SIX_W-1:0]       fault_six,
  input  logic [dfkcf_pkg::NIB_W-1:0]       want,
  output dfkcf_pkg::lane_res_t              res
);

  dfkcf_pkg::lane_res_t res_r;
  dfkcf_pkg::lane_res_t res_nxt;

  always_comb begin
    logic [dfkcf_pkg::SIX_W-1:0] guess;
    logic [dfkcf_pkg::NIB_W-1:0] got;
    res_nxt.tested = (fault_six != '0);
    for (int k = 0; k < dfkcf_pkg::GUESSES; k++) begin
      guess = dfkcf_pkg::SIX_W'(k);
      got   = dfkcf_pkg::sbox_lookup(lane_idx, r_six ^ guess) ^
              dfkcf_pkg::sbox_lookup(lane_idx, rf_six ^ guess);
      res_nxt.cand[k] = res_nxt.tested && (got == want);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/dfkcf_merge.sv =====
// ----------------------------------------------------------------------------
// DES fault key candidate filter merge stage
// Gathers the eight lane results into one item behind an output skid buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfkcf_merge (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       s1_valid,
  output logic                                       s1_ready,
  input  dfkcf_pkg::lane_res_t [dfkcf_pkg::LANES-1:0] lane_res,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output dfkcf_pkg::lane_res_t [dfkcf_pkg::LANES-1:0] out_res
);

  logic                                        out_valid_r;
  logic                                        out_valid_nxt;
  logic                                        skid_valid_r;
  logic                                        skid_valid_nxt;
  dfkcf_pkg::lane_res_t [dfkcf_pkg::LANES-1:0] out_res_r;
  dfkcf_pkg::lane_res_t [dfkcf_pkg::LANES-1:0] skid_res_r;
  logic                                        push;
  logic                                        free;

  assign s1_ready = !skid_valid_r;
  assign push     = s1_valid && !skid_valid_r;
  assign free     = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      out_res_r <= skid_valid_r ? skid_res_r : lane_res;
    end else if (push) begin
      skid_res_r <= lane_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `DFKCF_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid holds an item while output is empty")
  `DFKCF_ASSERT_IMP(a_skid_fill_on_stall, clk, rst_n, $rose(skid_valid_r), $past(out_valid_r && !out_ready), "skid filled without an output stall")
  `DFKCF_ASSERT_NXT(a_item_reaches_out, clk, rst_n, s1_valid && !out_valid_r && !skid_valid_r, out_valid_r, "lane result did not reach the output")

endmodule

// ===== rtl/core/des_fault_key_candidate_filter.sv =====
// ----------------------------------------------------------------------------
// DES fault key candidate filter
// Last-round differential fault analysis: eight S-box lanes test all 64
// subkey guesses of each faulted encryption and report the surviving ones.
// ----------------------------------------------------------------------------
// Each item on in_c describes one faulted DES encryption. Each item on out_c
// carries eight 64-bit candidate masks, one per S-box, and the mask of lanes
// that the fault touched. Every input item gives exactly one result item, in
// order.
// The lane registers take each item as it is accepted; the output register,
// which drives out_c.valid, then takes it from them, or from the skid
// register after a receiver stall. Throughput is one item per cycle while
// the receiver keeps out_c.ready high, set by the eight lanes, each of
// which compares all 64 guesses through two S-box table reads per guess
// combinationally.
// When the receiver stalls, the output register holds its item, a skid
// register takes one more and the lane registers a third, so in_c.ready
// drops once three items are waiting. Reset empties the lane stage, the
// output and the skid register; the block keeps no state between items.
// ----------------------------------------------------------------------------
module des_fault_key_candidate_filter (
  input  logic           clk,
  input  logic           rst_n,
  dfkcf_in_if.sink       in_c,
  dfkcf_out_if.source    out_c
);

  logic                                        s1_valid_r;
  logic                                        s1_valid_nxt;
  logic                                        s1_ready;
  logic                                        load;
  dfkcf_pkg::lane_res_t [dfkcf_pkg::LANES-1:0] lane_res;
  dfkcf_pkg::lane_res_t [dfkcf_pkg::LANES-1:0] out_res;

  assign in_c.ready = !s1_valid_r || s1_ready;
  assign load       = in_c.valid && in_c.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  for (genvar i = 0; i < dfkcf_pkg::LANES; i++) begin : g_lane
    localparam int unsigned Sh6 = 42 - 6 * i;
    localparam int unsigned Sh4 = 28 - 4 * i;

    dfkcf_lane u_lane (
      .clk       (clk),
      .load      (load),
      .lane_idx  (dfkcf_pkg::LANE_W'(i)),
      .r_six     (in_c.r15_expanded[Sh6 +: dfkcf_pkg::SIX_W]),
      .rf_six    (in_c.r15_faulty_expanded[Sh6 +: dfkcf_pkg::SIX_W]),
      .fault_six (in_c.fault_expanded[Sh6 +: dfkcf_pkg::SIX_W]),
      .want      (in_c.out_difference[Sh4 +: dfkcf_pkg::NIB_W]),
      .res       (lane_res[i])
    );

    assign out_c.lanes_tested[i] = out_res[i].tested;
  end

  dfkcf_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_ready  (s1_ready),
    .lane_res  (lane_res),
    .out_valid (out_c.valid),
    .out_ready (out_c.ready),
    .out_res   (out_res)
  );

  assign out_c.sbox1_candidates = out_res[0].cand;
  assign out_c.sbox2_candidates = out_res[1].cand;
  assign out_c.sbox3_candidates = out_res[2].cand;
  assign out_c.sbox4_candidates = out_res[3].cand;
  assign out_c.sbox5_candidates = out_res[4].cand;
  assign out_c.sbox6_candidates = out_res[5].cand;
  assign out_c.sbox7_candidates = out_res[6].cand;
  assign out_c.sbox8_candidates = out_res[7].cand;

endmodule

// ===== sim/tb_des_fault_key_candidate_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES fault key candidate filter testbench
// Drives faulted-encryption items into the filter, predicts the eight
// candidate masks and the tested-lane mask of each item, and compares every
// result with the prediction. Both channels idle at random, the receiver
// holds off once for a long stretch, and the run ends at full rate.
// ----------------------------------------------------------------------------
module tb_des_fault_key_candidate_filter;

  localparam int HOLD_CYCLES   = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 100;

  typedef struct packed {
    logic [dfkcf_pkg::EXP_W-1:0]  r15;
    logic [dfkcf_pkg::EXP_W-1:0]  r15_faulty;
    logic [dfkcf_pkg::DIFF_W-1:0] out_diff;
    logic [dfkcf_pkg::EXP_W-1:0]  fault;
  } fault_item_t;

  typedef struct packed {
    logic [dfkcf_pkg::LANES-1:0][dfkcf_pkg::GUESSES-1:0] cand;
    logic [dfkcf_pkg::LANES-1:0]                         tested;
  } candidate_set_t;

  localparam int des_sbox_table [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
  };

  logic clk;
  logic rst_n;

  dfkcf_in_if  in_c ();
  dfkcf_out_if out_c ();

  des_fault_key_candidate_filter dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_c  (in_c),
    .out_c (out_c)
  );

  candidate_set_t expected_q [$];
  int  mismatches        = 0;
  int  results_seen      = 0;
  int  lanes_tested_seen = 0;
  int  lanes_without_key = 0;
  int  items_sent        = 0;
  bit  tx_gaps_on        = 1'b1;
  bit  rx_stalls_on      = 1'b1;
  bit  hold_request      = 1'b0;

  function automatic logic [3:0] sbox_out(input int lane, input logic [5:0] six);
    return 4'(des_sbox_table[lane][{six[5], six[0], six[4:1]}]);
  endfunction

  function automatic logic [dfkcf_pkg::EXP_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic candidate_set_t predict_candidates(input fault_item_t item);
    candidate_set_t res;
    logic [5:0] a;
    logic [5:0] b;
    logic [3:0] want;
    res = '0;
    for (int lane = 0; lane < dfkcf_pkg::LANES; lane++) begin
      if (item.fault[42 - 6 * lane +: 6] != 6'd0) begin
        res.tested[lane] = 1'b1;
        a    = item.r15[42 - 6 * lane +: 6];
        b    = item.r15_faulty[42 - 6 * lane +: 6];
        want = item.out_diff[28 - 4 * lane +: 4];
        for (int k = 0; k < dfkcf_pkg::GUESSES; k++) begin
          if ((sbox_out(lane, a ^ 6'(k)) ^ sbox_out(lane, b ^ 6'(k))) == want) begin
            res.cand[lane][k] = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // A fault as seen after a real last-round upset: a few lanes touched, the
  // faulty half equal to the correct one xor the fault, and the output
  // difference consistent with a hidden subkey on the touched lanes.
  function automatic fault_item_t faithful_fault(input logic [dfkcf_pkg::EXP_W-1:0] key);
    fault_item_t item;
    logic [5:0] a;
    logic [5:0] b;
    item.r15      = rand48();
    item.out_diff = $urandom();
    item.fault    = '0;
    for (int lane = 0; lane < dfkcf_pkg::LANES; lane++) begin
      if ($urandom_range(0, 3) == 0) begin
        item.fault[42 - 6 * lane +: 6] = 6'($urandom_range(1, 63));
      end
    end
    if (item.fault == '0) begin
      item.fault[42 - 6 * $urandom_range(0, dfkcf_pkg::LANES - 1) +: 6] =
        6'($urandom_range(1, 63));
    end
    item.r15_faulty = item.r15 ^ item.fault;
    for (int lane = 0; lane < dfkcf_pkg::LANES; lane++) begin
      if (item.fault[42 - 6 * lane +: 6] != 6'd0) begin
        a = item.r15[42 - 6 * lane +: 6] ^ key[42 - 6 * lane +: 6];
        b = item.r15_faulty[42 - 6 * lane +: 6] ^ key[42 - 6 * lane +: 6];
        item.out_diff[28 - 4 * lane +: 4] = sbox_out(lane, a) ^ sbox_out(lane, b);
      end
    end
    return item;
  endfunction

  function automatic fault_item_t noise_fault();
    fault_item_t item;
    item.r15        = rand48();
    item.r15_faulty = rand48();
    item.out_diff   = $urandom();
    item.fault      = ($urandom_range(0, 2) == 0) ? rand48() & rand48() : rand48();
    return item;
  endfunction

  task automatic send_fault(input fault_item_t item);
    int gap;
    in_c.valid               <= 1'b1;
    in_c.r15_expanded        <= item.r15;
    in_c.r15_faulty_expanded <= item.r15_faulty;
    in_c.out_difference      <= item.out_diff;
    in_c.fault_expanded      <= item.fault;
    do @(posedge clk); while (in_c.ready !== 1'b1);
    expected_q.push_back(predict_candidates(item));
    items_sent++;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_c.valid               <= 1'b0;
      in_c.r15_expanded        <= rand48();
      in_c.r15_faulty_expanded <= rand48();
      in_c.out_difference      <= $urandom();
      in_c.fault_expanded      <= rand48();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_c.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end else if (mismatches == MAX_REPORTS + 1) begin
      $display("%0t: further mismatches are counted but not shown", $time);
    end
  endtask

  // Extreme field values: nothing tested, every guess passing, no guess
  // passing, and each of the two outer slice bits alone in every lane.
  task automatic test_extreme_fields();
    send_fault('{r15: '0, r15_faulty: '0, out_diff: '0, fault: '0});
    send_fault('{r15: '0, r15_faulty: '0, out_diff: '0, fault: '1});
    send_fault('{r15: '1, r15_faulty: '1, out_diff: '1, fault: '1});
    send_fault('{r15: '1, r15_faulty: '0, out_diff: '0, fault: '1});
    send_fault('{r15: '1, r15_faulty: '0, out_diff: '1, fault: '1});
    send_fault('{r15: '0, r15_faulty: '1, out_diff: 32'h5a5a_a5a5,
                 fault: 48'h8208_2082_0820});
    send_fault('{r15: rand48(), r15_faulty: rand48(), out_diff: $urandom(),
                 fault: 48'h0410_4104_1041});
  endtask

  task automatic test_single_lanes();
    fault_item_t item;
    for (int lane = 0; lane < dfkcf_pkg::LANES; lane++) begin
      item       = noise_fault();
      item.fault = '0;
      item.fault[42 - 6 * lane +: 6] = (lane % 2 == 0) ? 6'h3f : 6'h01;
      send_fault(item);
    end
  endtask

  task automatic test_faithful_faults(input int count);
    logic [dfkcf_pkg::EXP_W-1:0] key;
    key = rand48();
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) key = rand48();
      send_fault(faithful_fault(key));
    end
  endtask

  task automatic test_noise_items(input int count);
    for (int i = 0; i < count; i++) send_fault(noise_fault());
  endtask

  // The receiver holds off while items keep coming, so the output and skid
  // registers fill and the input stalls.
  task automatic test_output_backpressure();
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    test_faithful_faults(16);
    tx_gaps_on = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    for (int burst = 0; burst < 3; burst++) begin
      test_faithful_faults(10);
      wait_results_drained();
    end
  endtask

  task automatic test_full_rate(input int count);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_fault(($urandom_range(0, 3) == 0) ? noise_fault() : faithful_fault(rand48()));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    int hold_left;
    int stall_left;
    hold_left   = 0;
    stall_left  = 0;
    out_c.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_c.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_c.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_c.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_c.ready <= 1'b0;
      end else begin
        out_c.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    candidate_set_t got;
    candidate_set_t want;
    if (rst_n && out_c.valid === 1'b1 && out_c.ready === 1'b1) begin
      got.cand[0] = out_c.sbox1_candidates;
      got.cand[1] = out_c.sbox2_candidates;
      got.cand[2] = out_c.sbox3_candidates;
      got.cand[3] = out_c.sbox4_candidates;
      got.cand[4] = out_c.sbox5_candidates;
      got.cand[5] = out_c.sbox6_candidates;
      got.cand[6] = out_c.sbox7_candidates;
      got.cand[7] = out_c.sbox8_candidates;
      got.tested  = out_c.lanes_tested;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, lanes_tested", '0, 64'(got.tested));
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        for (int lane = 0; lane < dfkcf_pkg::LANES; lane++) begin
          if (got.cand[lane] !== want.cand[lane]) begin
            report_mismatch($sformatf("sbox%0d_candidates", lane + 1),
                            want.cand[lane], got.cand[lane]);
          end
          if (want.tested[lane] && want.cand[lane] == '0) lanes_without_key++;
        end
        if (got.tested !== want.tested) begin
          report_mismatch("lanes_tested", 64'(want.tested), 64'(got.tested));
        end
        lanes_tested_seen += $countones(want.tested);
      end
    end
  end

  initial begin
    rst_n                    = 1'b0;
    in_c.valid               = 1'b0;
    in_c.r15_expanded        = '0;
    in_c.r15_faulty_expanded = '0;
    in_c.out_difference      = '0;
    in_c.fault_expanded      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_extreme_fields();
    test_single_lanes();
    test_faithful_faults(900);
    test_noise_items(250);
    test_output_backpressure();
    test_sender_pause();
    test_full_rate(200);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d fault items and checked %0d results, %0d lanes tested.",
             items_sent, results_seen, lanes_tested_seen);
    $display("Tested lanes with no surviving guess: %0d; mismatches: %0d.",
             lanes_without_key, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
